FILE: rtl/lca_pkg.sv
package lca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int JUMP_LEVELS = 10;
  localparam int ID_W        = 11;
  localparam int DEPTH_W     = 10;
  localparam int OP_W        = 2;
  localparam int LVL_W       = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
  localparam int JUMP_DEPTH  = (MAX_NODES + 1) * JUMP_LEVELS;
  localparam int JADDR_W     = $clog2(JUMP_DEPTH);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [JADDR_W-1:0] jaddr_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_BUILD = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

  typedef struct packed {
    logic latch_in;
    logic ld_write;
    logic bld_init;
    logic bld_rd1;
    logic bld_rd2;
    logic bld_wr;
    logic q_rda;
    logic q_rdb;
    logic q_swap;
    logic p1_rdj;
    logic p1_cap;
    logic p1_dep;
    logic lvl_dec;
    logic lvl_top;
    logic p2_rd;
    logic p2_upd;
    logic fin_rd;
    logic fin_cap;
    logic out_fin;
    logic out_dir;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic q_bad;
    logic bld_none;
    logic da_zero;
    logic a_eq_b;
    logic p1_take;
    logic lvl_zero;
    logic j_last;
    logic k_last;
    logic out_free;
  } stat_t;

  // flat index of (node, level) in the jump table
  function automatic jaddr_t jidx(input id_t id, input lvl_t lvl);
    jaddr_t base;
    base = JADDR_W'(id) * JADDR_W'(JUMP_LEVELS);
    return base + JADDR_W'(lvl);
  endfunction

  // largest level i with 2^i <= d, capped at the top table level
  function automatic lvl_t top_level(input depth_t d);
    lvl_t t;
    t = '0;
    for (int i = 1; i < JUMP_LEVELS; i++) begin
      if ((32'd1 << i) <= 32'(d)) t = LVL_W'(i);
    end
    return t;
  endfunction

endpackage

FILE: rtl/lca_ctrl.sv
module lca_ctrl import lca_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_B_RD1  = 5'd2;
  localparam logic [4:0] S_B_RD2  = 5'd3;
  localparam logic [4:0] S_B_WR   = 5'd4;
  localparam logic [4:0] S_Q_DB   = 5'd5;
  localparam logic [4:0] S_Q_SW   = 5'd6;
  localparam logic [4:0] S_Q_TOP  = 5'd7;
  localparam logic [4:0] S_P1_CHK = 5'd8;
  localparam logic [4:0] S_P1_CAP = 5'd9;
  localparam logic [4:0] S_P1_DEP = 5'd10;
  localparam logic [4:0] S_P1_END = 5'd11;
  localparam logic [4:0] S_P2_RD  = 5'd12;
  localparam logic [4:0] S_P2_UPD = 5'd13;
  localparam logic [4:0] S_F_RD   = 5'd14;
  localparam logic [4:0] S_F_CAP  = 5'd15;
  localparam logic [4:0] S_F_DEP  = 5'd16;
  localparam logic [4:0] S_OUT_A  = 5'd17;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        unique case (st.op)
          OP_LOAD: begin
            cmd.ld_write = 1'b1;
            state_nxt    = S_IDLE;
          end
          OP_BUILD: begin
            if (st.bld_none) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.bld_init = 1'b1;
              state_nxt    = S_B_RD1;
            end
          end
          OP_QUERY: begin
            if (st.q_bad) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.q_rda = 1'b1;
              state_nxt = S_Q_DB;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_B_RD1: begin
        cmd.bld_rd1 = 1'b1;
        state_nxt   = S_B_RD2;
      end
      S_B_RD2: begin
        cmd.bld_rd2 = 1'b1;
        state_nxt   = S_B_WR;
      end
      S_B_WR: begin
        cmd.bld_wr = 1'b1;
        state_nxt  = (st.j_last && st.k_last) ? S_IDLE : S_B_RD1;
      end
      S_Q_DB: begin
        cmd.q_rdb = 1'b1;
        state_nxt = S_Q_SW;
      end
      S_Q_SW: begin
        cmd.q_swap = 1'b1;
        state_nxt  = S_Q_TOP;
      end
      S_Q_TOP: begin
        if (st.da_zero) state_nxt = st.a_eq_b ? S_OUT_A : S_F_RD;
        else            state_nxt = S_P1_CHK;
      end
      S_P1_CHK: begin
        if (st.p1_take) begin
          cmd.p1_rdj = 1'b1;
          state_nxt  = S_P1_CAP;
        end else if (st.lvl_zero) begin
          state_nxt = S_P1_END;
        end else begin
          cmd.lvl_dec = 1'b1;
        end
      end
      S_P1_CAP: begin
        cmd.p1_cap = 1'b1;
        state_nxt  = S_P1_DEP;
      end
      S_P1_DEP: begin
        cmd.p1_dep = 1'b1;
        if (st.lvl_zero) begin
          state_nxt = S_P1_END;
        end else begin
          cmd.lvl_dec = 1'b1;
          state_nxt   = S_P1_CHK;
        end
      end
      S_P1_END: begin
        if (st.a_eq_b) begin
          state_nxt = S_OUT_A;
        end else begin
          cmd.lvl_top = 1'b1;
          state_nxt   = S_P2_RD;
        end
      end
      S_P2_RD: begin
        cmd.p2_rd = 1'b1;
        state_nxt = S_P2_UPD;
      end
      S_P2_UPD: begin
        cmd.p2_upd = 1'b1;
        if (st.lvl_zero) begin
          state_nxt = S_F_RD;
        end else begin
          cmd.lvl_dec = 1'b1;
          state_nxt   = S_P2_RD;
        end
      end
      S_F_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = S_F_CAP;
      end
      S_F_CAP: begin
        cmd.fin_cap = 1'b1;
        state_nxt   = S_F_DEP;
      end
      S_F_DEP: begin
        if (st.out_free) begin
          cmd.out_fin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_OUT_A: begin
        if (st.out_free) begin
          cmd.out_dir = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/lca_dp.sv
module lca_dp import lca_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  id_t    cfg_wdata,
  input  op_t    in_op,
  input  id_t    in_node,
  input  id_t    in_parent,
  input  depth_t in_depth,
  input  id_t    in_other,
  input  cmd_t   cmd,
  output stat_t  st,
  output logic   out_valid,
  input  logic   out_ready,
  output id_t    out_ancestor,
  output depth_t out_anc_depth
);

  logic [JUMP_LEVELS*0+ID_W-1:0] jmem [0:JUMP_DEPTH-1];
  depth_t                        dmem [0:MAX_NODES];

  op_t    op_r;
  id_t    node_r, par_r, oth_r;
  depth_t depin_r;
  id_t    a_r, b_r, j_r, node_count_r;
  depth_t da_r, db_r;
  lvl_t   lvl_r, top_r, k_r;
  id_t    jrd_a_r, jrd_b_r;
  logic   jz_a_r, jz_b_r;
  depth_t drd_r;
  logic   dz_r;
  logic   out_valid_r;
  id_t    out_anc_r;
  depth_t out_dep_r;

  id_t    lim, ja, jb, ja_id, d_id, jw_data;
  lvl_t   ja_lvl;
  jaddr_t jw_addr;
  logic   ja_re, d_re, jw_en, load_ok, swap, out_free;
  depth_t d_eff, da_sw;

  // id 0 is the fixed "no node" entry: all reads of it give zero
  assign ja    = jz_a_r ? '0 : jrd_a_r;
  assign jb    = jz_b_r ? '0 : jrd_b_r;
  assign d_eff = dz_r ? '0 : drd_r;

  assign lim     = (node_count_r > ID_W'(MAX_NODES)) ? ID_W'(MAX_NODES) : node_count_r;
  assign load_ok = (node_r != '0) && (node_r <= ID_W'(MAX_NODES));
  assign swap    = (da_r < d_eff);
  assign da_sw   = swap ? d_eff : da_r;
  assign out_free = !out_valid_r || out_ready;

  assign st.op       = op_r;
  assign st.q_bad    = (node_r == '0) || (oth_r == '0) || (node_r > lim) || (oth_r > lim);
  assign st.bld_none = (lim == '0) || (JUMP_LEVELS < 2);
  assign st.da_zero  = (da_r == '0);
  assign st.a_eq_b   = (a_r == b_r);
  assign st.p1_take  = {1'b0, da_r} >= ({1'b0, db_r} + ((DEPTH_W+1)'(1) << lvl_r));
  assign st.lvl_zero = (lvl_r == '0);
  assign st.j_last   = (j_r == lim);
  assign st.k_last   = (k_r == LVL_W'(JUMP_LEVELS - 1));
  assign st.out_free = out_free;

  // jump table read port A
  always_comb begin
    ja_id  = a_r;
    ja_lvl = lvl_r;
    if (cmd.bld_rd1) begin
      ja_id  = j_r;
      ja_lvl = k_r - LVL_W'(1);
    end else if (cmd.bld_rd2) begin
      ja_id  = ja;
      ja_lvl = k_r - LVL_W'(1);
    end else if (cmd.fin_rd) begin
      ja_lvl = '0;
    end
  end
  assign ja_re = cmd.bld_rd1 | cmd.bld_rd2 | cmd.p1_rdj | cmd.p2_rd | cmd.fin_rd;

  // depth read port
  always_comb begin
    d_id = ja;
    if (cmd.q_rda)      d_id = a_r;
    else if (cmd.q_rdb) d_id = b_r;
  end
  assign d_re = cmd.q_rda | cmd.q_rdb | cmd.p1_cap | cmd.fin_cap;

  // jump table write port: level 0 on load, higher levels on build
  always_comb begin
    jw_en   = 1'b0;
    jw_addr = jidx(j_r, k_r);
    jw_data = ja;
    if (cmd.ld_write) begin
      jw_en   = load_ok;
      jw_addr = jidx(node_r, '0);
      jw_data = (par_r <= ID_W'(MAX_NODES)) ? par_r : '0;
    end else if (cmd.bld_wr) begin
      jw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (jw_en) jmem[jw_addr] <= jw_data;
    if (ja_re) begin
      jrd_a_r <= jmem[jidx(ja_id, ja_lvl)];
      jz_a_r  <= (ja_id == '0);
    end
    if (cmd.p2_rd) begin
      jrd_b_r <= jmem[jidx(b_r, lvl_r)];
      jz_b_r  <= (b_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_write && load_ok) dmem[node_r] <= depin_r;
    if (d_re) begin
      drd_r <= dmem[d_id];
      dz_r  <= (d_id == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_op;
      node_r  <= in_node;
      par_r   <= in_parent;
      depin_r <= in_depth;
      oth_r   <= in_other;
      a_r     <= in_node;
      b_r     <= in_other;
    end
    if (cmd.bld_init) begin
      j_r <= ID_W'(1);
      k_r <= LVL_W'(1);
    end else if (cmd.bld_wr) begin
      if (j_r == lim) begin
        j_r <= ID_W'(1);
        k_r <= k_r + LVL_W'(1);
      end else begin
        j_r <= j_r + ID_W'(1);
      end
    end
    if (cmd.q_rdb) da_r <= d_eff;
    if (cmd.q_swap) begin
      if (swap) begin
        a_r  <= b_r;
        b_r  <= a_r;
        da_r <= d_eff;
        db_r <= da_r;
      end else begin
        db_r <= d_eff;
      end
      top_r <= top_level(da_sw);
      lvl_r <= top_level(da_sw);
    end
    if (cmd.p1_cap) a_r  <= ja;
    if (cmd.p1_dep) da_r <= d_eff;
    if (cmd.p2_upd && (ja != '0) && (ja != jb)) begin
      a_r <= ja;
      b_r <= jb;
    end
    if (cmd.lvl_top)      lvl_r <= top_r;
    else if (cmd.lvl_dec) lvl_r <= lvl_r - LVL_W'(1);
    if (cmd.out_fin) begin
      out_anc_r <= ja;
      out_dep_r <= d_eff;
    end else if (cmd.out_dir) begin
      out_anc_r <= a_r;
      out_dep_r <= da_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= ID_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      if (cmd.out_fin || cmd.out_dir) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ancestor  = out_anc_r;
  assign out_anc_depth = out_dep_r;

endmodule

FILE: rtl/lowest_common_ancestor_engine_unit.sv
// Binary-lifting lowest common ancestor engine. Requests arrive on the in_ stream with the
// opcode in in_tuser: load stores one node's parent and depth, build fills jump levels 1..9
// for nodes 1..min(node_count,1024) level by level, and query returns the common ancestor and
// its depth on the out_ stream. A query whose deeper node is at depth 0 gives that node when
// both nodes are the same and its parent otherwise. Any other query lifts the deeper node over
// the levels in use (a check per level, a jump and a depth read per lift taken), then climbs
// both (a read and an update per level); it ends after the first pass instead when the lifted
// node meets the other one. Each step waits on a registered read of the jump table or depth
// store, and a result that is not taken holds the engine. Invalid queries, the unused op and
// a build with node_count 0 return to idle from decode. Load, build and invalid queries give
// no result. The stores have no reset and must be loaded before use; the user must write
// node_count through cfg_we/cfg_wdata only while the engine is idle; the block itself does not enforce it.
module lowest_common_ancestor_engine_unit import lca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [ID_W-1:0]        cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // node[10:0], parent[21:11], depth[31:22], other_node[42:32], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // ancestor[10:0], ancestor_depth[20:11], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cmd_t   cmd;
  stat_t  st;
  id_t    out_ancestor;
  depth_t out_anc_depth;

  lca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lca_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_tuser),
    .in_node       (in_tdata[ID_W-1:0]),
    .in_parent     (in_tdata[2*ID_W-1:ID_W]),
    .in_depth      (in_tdata[2*ID_W+DEPTH_W-1:2*ID_W]),
    .in_other      (in_tdata[3*ID_W+DEPTH_W-1:2*ID_W+DEPTH_W]),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_ancestor  (out_ancestor),
    .out_anc_depth (out_anc_depth)
  );

  assign out_tdata = {{(OUT_TDATA_W-ID_W-DEPTH_W){1'b0}}, out_anc_depth, out_ancestor};

endmodule

FILE: rtl/lca_checker.sv
module lca_checker import lca_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // no early result after a request accepted while no result is pending
  a_no_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early");

  // the no-node answer always reports depth zero
  a_null_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[ID_W-1:0] == '0) |-> (out_tdata[ID_W+DEPTH_W-1:ID_W] == '0))
    else $error("no-node ancestor with nonzero depth");

endmodule

bind lowest_common_ancestor_engine_unit lca_checker u_lca_checker (.*);

FILE: sim/lca_answer_checker.sv
`timescale 1ns / 1ps

module lca_answer_checker import lca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [ID_W-1:0]        cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // node[10:0], parent[21:11], depth[31:22], other_node[42:32], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // ancestor[10:0], ancestor_depth[20:11], zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     answers_due
);

  typedef struct packed {
    id_t    ancestor;
    depth_t depth;
  } answer_t;

  answer_t         awaited_answers[$];
  depth_t          depth_mem [0:MAX_NODES];
  id_t             jump_mem  [0:MAX_NODES][0:JUMP_LEVELS-1];
  logic [ID_W-1:0] node_total;

  initial begin
    mismatch_count = 0;
    answers_due = 0;
  end

  function automatic id_t clamp_id(input id_t v);
    return (v <= MAX_NODES) ? v : '0;
  endfunction

  function automatic id_t jump_of(input id_t id, input int lvl);
    if (id > MAX_NODES) return '0;
    return jump_mem[id][lvl];
  endfunction

  function automatic depth_t depth_at(input id_t id);
    if (id > MAX_NODES) return '0;
    return depth_mem[id];
  endfunction

  function automatic int nodes_in_use();
    return (node_total < MAX_NODES) ? int'(node_total) : MAX_NODES;
  endfunction

  // level k of node j becomes the 2^k-th ancestor, level by level
  function automatic void fill_jump_levels();
    id_t mid;
    int  lim;
    lim = nodes_in_use();
    for (int k = 1; k < JUMP_LEVELS; k++) begin
      for (int j = 1; j <= lim; j++) begin
        mid = jump_mem[j][k-1];
        jump_mem[j][k] = (mid == 0) ? '0 : clamp_id(jump_of(mid, k - 1));
      end
    end
  endfunction

  function automatic id_t common_ancestor(input id_t x, input id_t y);
    id_t a, b, t, ja, jb;
    int  top;
    a = x;
    b = y;
    if (depth_at(a) < depth_at(b)) begin
      t = a;
      a = b;
      b = t;
    end
    top = 0;
    while (top + 1 < JUMP_LEVELS && (1 << (top + 1)) <= int'(depth_at(a))) top++;
    if (depth_at(a) == 0) return (a == b) ? a : clamp_id(jump_of(a, 0));
    // bring the deeper node up to the other's depth
    for (int i = top; i >= 0; i--) begin
      if (int'(depth_at(a)) >= int'(depth_at(b)) + (1 << i)) a = clamp_id(jump_of(a, i));
    end
    if (a == b) return a;
    // climb both while their ancestors still differ
    for (int i = top; i >= 0; i--) begin
      ja = clamp_id(jump_of(a, i));
      jb = clamp_id(jump_of(b, i));
      if (ja != 0 && ja != jb) begin
        a = ja;
        b = jb;
      end
    end
    return clamp_id(jump_of(a, 0));
  endfunction

  always @(posedge clk) begin : watch
    id_t     nd, par, oth, anc;
    depth_t  dep;
    answer_t got, want;
    if (!rst_n) begin
      for (int i = 0; i <= MAX_NODES; i++) begin
        depth_mem[i] = '0;
        for (int k = 0; k < JUMP_LEVELS; k++) jump_mem[i][k] = '0;
      end
      node_total = 1;
      awaited_answers.delete();
      answers_due = 0;
    end else begin
      if (cfg_we) node_total = cfg_wdata;

      // results first: one leaving now belongs to an earlier request
      if (out_tvalid && out_tready) begin
        got.ancestor = out_tdata[10:0];
        got.depth = out_tdata[20:11];
        if (awaited_answers.size() == 0) begin
          $display("%0t: result with no query waiting: expected none, got ancestor %0d depth %0d",
                   $time, got.ancestor, got.depth);
          mismatch_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (got.ancestor !== want.ancestor || got.depth !== want.depth) begin
            if (got.ancestor !== want.ancestor)
              $display("%0t: ancestor mismatch: expected %0d, got %0d",
                       $time, want.ancestor, got.ancestor);
            if (got.depth !== want.depth)
              $display("%0t: ancestor_depth mismatch: expected %0d, got %0d",
                       $time, want.depth, got.depth);
            mismatch_count++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        nd  = in_tdata[10:0];
        par = in_tdata[21:11];
        dep = in_tdata[31:22];
        oth = in_tdata[42:32];
        unique case (in_tuser)
          OP_LOAD: begin
            if (nd != 0 && nd <= MAX_NODES) begin
              depth_mem[nd] = dep;
              jump_mem[nd][0] = clamp_id(par);
            end
          end
          OP_BUILD: fill_jump_levels();
          OP_QUERY: begin
            if (nd != 0 && oth != 0 && nd <= nodes_in_use() && oth <= nodes_in_use()) begin
              anc = common_ancestor(nd, oth);
              want.ancestor = anc;
              want.depth = depth_at(anc);
              awaited_answers.insert(awaited_answers.size(), want);
            end
          end
          default: ;
        endcase
      end

      answers_due = awaited_answers.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb import lca_pkg::*; ();

  localparam op_t OP_SPARE = 2'd3;

  typedef struct {
    op_t    op;
    id_t    node;
    id_t    parent;
    depth_t depth;
    id_t    other;
  } request_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [ID_W-1:0]        cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int       mismatch_count;
  int       answers_due;
  request_t req_queue[$];
  int       pushed_count = 0;
  int       sent_count = 0;
  int       node_used = 1;
  int       tree_depth [0:MAX_NODES];
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       hold_len = 0;

  always #4 clk = ~clk;

  lowest_common_ancestor_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lca_answer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .answers_due    (answers_due)
  );

  // request driver: drains req_queue, random gaps unless calm
  initial begin : sender
    request_t r;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (req_queue.size() == 0) begin
        in_tvalid = 1'b0;
      end else begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_tvalid = 1'b0;
          repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        r = req_queue.pop_front();
        in_tdata = {{(IN_TDATA_W-43){1'b0}}, r.other, r.depth, r.parent, r.node};
        in_tuser = r.op;
        in_tvalid = 1'b1;
        do @(posedge clk); while (!in_tready);
        sent_count++;
      end
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
        out_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    #16_000_000;
    $display("lowest_common_ancestor_engine_unit verification failed");
    $finish;
  end

  task automatic post(input op_t op, input int node, input int parent, input int depth,
                      input int other);
    request_t r;
    r.op = op;
    r.node = node[ID_W-1:0];
    r.parent = parent[ID_W-1:0];
    r.depth = depth[DEPTH_W-1:0];
    r.other = other[ID_W-1:0];
    req_queue.insert(req_queue.size(), r);
    pushed_count++;
  endtask

  task automatic post_load(input int node, input int parent, input int depth);
    post(OP_LOAD, node, parent, depth, $urandom_range(0, 2047));
  endtask

  task automatic post_query(input int a, input int b);
    post(OP_QUERY, a, $urandom_range(0, 2047), $urandom_range(0, 1023), b);
  endtask

  task automatic post_build();
    post(OP_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 1023),
         $urandom_range(0, 2047));
  endtask

  task automatic drain();
    wait (sent_count == pushed_count);
    @(negedge clk);
    wait (answers_due == 0);
  endtask

  // a build may still be running after the last answer; give it its full time
  task automatic set_node_count(input int v);
    drain();
    repeat (27 * node_used + 200) @(negedge clk);
    cfg_wdata = v[ID_W-1:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    node_used = (v < MAX_NODES) ? v : MAX_NODES;
  endtask

  task automatic run_phase(input int count_value, input int nq, input bit fresh_tree,
                           input bit with_hold);
    int lim, p, d, a, b, pick;
    set_node_count(count_value);
    lim = node_used;
    if (fresh_tree) begin
      // mostly long chains so the upper jump levels get used
      for (int i = 1; i <= lim; i++) begin
        if (i == 1 || $urandom_range(0, 40) == 0) begin
          p = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_NODES + 1, 2047) : 0;
          d = 0;
        end else begin
          p = ($urandom_range(0, 3) != 0) ? i - 1 : $urandom_range(1, i - 1);
          d = (tree_depth[p] < 1023) ? tree_depth[p] + 1 : 1023;
        end
        if ($urandom_range(0, 30) == 0) d = $urandom_range(0, 1023);
        tree_depth[i] = d;
        post_load(i, p, d);
      end
    end
    post_build();
    if (with_hold) begin
      drain();
      hold_len = 27 * lim + 400;
      hold_req = 1'b1;
    end
    for (int q = 0; q < nq; q++) begin
      if (q == nq / 2 && $urandom_range(0, 2) == 0) drain();
      pick = $urandom_range(0, 11);
      if (lim == 0 || pick == 1) begin
        a = $urandom_range(0, 1) ? 0 : $urandom_range(lim + 1, 2047);
        b = (lim == 0) ? $urandom_range(0, 2047) : $urandom_range(1, lim);
        if ($urandom_range(0, 1)) post_query(a, b);
        else post_query(b, a);
      end else if (pick == 0) begin
        post(OP_SPARE, $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom_range(0, 1023), $urandom_range(0, 2047));
      end else if (pick == 2) begin
        post_load($urandom_range(0, 1) ? 0 : $urandom_range(MAX_NODES + 1, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (pick == 3 && lim <= 64) begin
        post_build();
      end else begin
        a = $urandom_range(1, lim);
        b = ($urandom_range(0, 7) == 0) ? a : $urandom_range(1, lim);
        post_query(a, b);
      end
    end
  endtask

  initial begin : stimulus
    int n;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // small hand-built forest
    set_node_count(8);
    post_load(1, 0, 0);
    post_load(2, 1, 1);
    post_load(3, 1, 1);
    post_load(4, 2, 2);
    post_load(5, 4, 3);
    post_load(6, 2047, 0);     // out-of-range parent: second root
    post_load(7, 6, 1);
    post_load(8, 5, 1023);     // depth far off its real chain
    post_load(0, 3, 5);        // ignored ids
    post_load(2047, 1, 1);
    post_load(1025, 2, 4);
    post_load(1024, 1024, 1023);
    post_build();
    post_query(5, 3);
    post_query(4, 5);          // one node is the other's ancestor
    post_query(1, 1);
    post_query(1, 6);          // two roots, nothing shared
    post_query(5, 7);
    post_query(8, 3);
    post_query(7, 6);
    post_query(3, 8);
    post_query(0, 3);          // no answer expected for these
    post_query(3, 9);
    post_query(2047, 2047);
    post(OP_SPARE, 2047, 2047, 1023, 2047);

    // full-size table, then a count past the table size
    run_phase(1024, 40, 1'b1, 1'b0);
    run_phase(2047, 30, 1'b0, 1'b1);
    run_phase(0, 6, 1'b0, 1'b0);
    run_phase(1, 6, 1'b1, 1'b0);

    while (pushed_count < 1650) begin
      calm = (pushed_count > 1450) ? 1'b1 : ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 120) : $urandom_range(2, 40);
      run_phase(n, $urandom_range(n, 2 * n + 10), 1'b1, 1'b0);
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && answers_due == 0) begin
      $display("lowest_common_ancestor_engine_unit verification clean");
    end else begin
      $display("lowest_common_ancestor_engine_unit verification failed");
    end
    $finish;
  end

endmodule
